FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the water balance block.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Antecedent true implies consequent true in the same cycle.
`define RRWB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent true implies consequent true in the next cycle.
`define RRWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hw/rtl/rrwb_pkg.sv
// Package of the rainfall runoff water balance block: types, constants, table.
// Depends on nothing; used by the multiplier, the divider and the top level.
package rrwb_pkg;

  localparam int unsigned DIVIDEND_W = 52;
  localparam int unsigned DIVISOR_W = 31;
  localparam int unsigned QUOT_W = 20;
  localparam int unsigned MUL_W = 33;
  localparam int unsigned EXP_BITS = 20;

  localparam logic [31:0] IMPERVIOUS_THRESHOLD_DEF = 32'd65536;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [30:0] CAP_MAX = 31'h7FFF_FFFF;
  localparam logic [19:0] TEN_MM_Q16 = 20'd655360;

  localparam logic [16:0] PF_RST = 17'd65536;
  localparam logic [31:0] ICAP_RST = 32'd65536;
  localparam logic [31:0] ICOEF_RST = 32'd13107200;
  localparam logic [19:0] ISHAPE_RST = 20'd196608;
  localparam logic [31:0] SCAP_RST = 32'd16384000;
  localparam logic [16:0] SUB_RST = 17'd32768;
  localparam logic [16:0] CRAK_RST = 17'd32768;
  localparam logic [16:0] BF_RST = 17'd6554;
  localparam logic [31:0] SOIL_RST = 32'd8192000;

  typedef enum logic [2:0] {
    REG_PERVIOUS_FRACTION = 3'd0,
    REG_INTERCEPTION_CAP  = 3'd1,
    REG_INFILTRATION_COEF = 3'd2,
    REG_INFILTRATION_SHP  = 3'd3,
    REG_SOIL_CAPACITY     = 3'd4,
    REG_INTERFLOW_COEF    = 3'd5,
    REG_RECHARGE_COEF     = 3'd6,
    REG_BASEFLOW_COEF     = 3'd7
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_DIV1, S_M5, S_M6, S_EXP, S_EXPW,
    S_M7, S_M8, S_M9, S_M10, S_M11, S_M12, S_M13, S_M14, S_DIV2, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  localparam logic [31:0] NEG_EXP_TAB [EXP_BITS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

endpackage

FILE: hw/rtl/rrwb_mul.sv
// Shared registered multiplier of the water balance block.
// Depends on rrwb_pkg for the operand width.
module rrwb_mul (
  input  logic                             clk,
  input  logic [rrwb_pkg::MUL_W-1:0]       a,
  input  logic [rrwb_pkg::MUL_W-1:0]       b,
  output logic [2*rrwb_pkg::MUL_W-1:0]     prod_r
);

  logic [2*rrwb_pkg::MUL_W-1:0] prod_nxt;

  assign prod_nxt = {{rrwb_pkg::MUL_W{1'b0}}, a} * {{rrwb_pkg::MUL_W{1'b0}}, b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: hw/rtl/rrwb_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, quotient below 2^20.
// Depends on rrwb_pkg for the request and response types.
module rrwb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rrwb_pkg::div_req_t  req,
  output rrwb_pkg::div_rsp_t  rsp
);

  localparam int unsigned QW = rrwb_pkg::QUOT_W;
  localparam int unsigned DW = rrwb_pkg::DIVISOR_W;
  localparam int unsigned CW = $clog2(QW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.dividend[rrwb_pkg::DIVIDEND_W-2:QW];
      quo_nxt  = req.dividend[QW-1:0];
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: hw/rtl/rainfall_runoff_water_balance_step.sv
// A normal step runs the multiply states, a division of the soil level by the soil
// capacity, the 20-bit exponent walk, more multiply states and, unless the soil ends
// the step empty, a second division by the soil capacity; a series start goes straight
// to the result. All products share one multiplier; the divider is a separate unit.
// The block takes no new input until its result has been taken; in_ready
// is high only when idle. Reset (synchronous, active low) loads register defaults,
// soil to half capacity and groundwater to zero.
module rainfall_runoff_water_balance_step #(
  parameter logic [31:0] IMPERVIOUS_THRESHOLD = rrwb_pkg::IMPERVIOUS_THRESHOLD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_series_start,
  input  logic [31:0] in_rainfall,
  input  logic [31:0] in_potential_et,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_total_runoff,
  output logic [31:0] out_actual_et,
  output logic [31:0] out_excess_after_interception,
  output logic [31:0] out_interception_loss,
  output logic [31:0] out_direct_runoff,
  output logic [31:0] out_interflow,
  output logic [31:0] out_infiltration,
  output logic signed [31:0] out_soil_level,
  output logic [31:0] out_recharge,
  output logic signed [31:0] out_groundwater_level,
  output logic [31:0] out_soil_et,
  output logic [31:0] out_baseflow
);

  localparam int unsigned MW = rrwb_pkg::MUL_W;

  rrwb_pkg::state_t state_r, state_nxt;

  logic [16:0] pf_cfg_r, sub_cfg_r, crak_cfg_r, bf_cfg_r;
  logic [31:0] icap_cfg_r, icoef_cfg_r, scap_cfg_r;
  logic [19:0] shape_cfg_r;
  logic signed [31:0] soil_r;
  logic [31:0] gw_r;

  logic [31:0] rain_r, pet_r;
  logic [31:0] imp_p_r, per_p_r, imp_et_r, imp_q_r, intc_r, inr_r;
  logic [16:0] ratio_r;
  logic [19:0] x_r;
  logic [32:0] acc_r;
  logic [4:0]  bit_r;
  logic [31:0] rmo_r, irun_r, srun_r, rest_r, bas_r, et_r;
  logic [33:0] rec_r;
  logic signed [31:0] lvl_r;

  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod_r;
  logic [2*MW-1:0] prod_rnd;
  rrwb_pkg::div_req_t div_req;
  rrwb_pkg::div_rsp_t div_rsp;

  logic [16:0] pf, imp, sub_f, crak_f, bf_f;
  logic [30:0] cap;
  logic [30:0] soil_pos;
  logic [31:0] thr, imp_et, intc, infc, rmo, srun, rec;
  logic signed [33:0] lvl_sum;
  logic signed [33:0] cap_s;
  logic [34:0] g_sum;
  logic [30:0] g_sat;
  logic [33:0] tot, tet;
  logic [31:0] et_div;
  logic signed [31:0] soil_fin;
  logic [31:0] gw_fin;

  function automatic logic [16:0] frac(input logic [16:0] v);
    frac = (v > rrwb_pkg::ONE_Q16) ? rrwb_pkg::ONE_Q16 : v;
  endfunction

  function automatic logic [31:0] min2(input logic [31:0] a, input logic [31:0] b);
    min2 = (a < b) ? a : b;
  endfunction

  assign pf     = frac(pf_cfg_r);
  assign imp    = rrwb_pkg::ONE_Q16 - pf;
  assign sub_f  = frac(sub_cfg_r);
  assign crak_f = frac(crak_cfg_r);
  assign bf_f   = frac(bf_cfg_r);
  assign cap    = (scap_cfg_r == 32'd0) ? 31'd1 :
                  (scap_cfg_r > {1'b0, rrwb_pkg::CAP_MAX}) ? rrwb_pkg::CAP_MAX :
                  scap_cfg_r[30:0];
  assign soil_pos = (soil_r <= 32'sd0) ? 31'd0 :
                    (soil_r[30:0] > cap) ? cap : soil_r[30:0];

  assign thr      = prod_r[47:16];
  assign imp_et   = min2(min2(pet_r, thr), imp_p_r);
  assign intc     = min2(min2(icap_cfg_r, pet_r), per_p_r);
  assign prod_rnd = prod_r + (2*MW)'(64'h8000_0000);
  assign infc     = prod_r[63:32];
  assign rmo      = min2(infc, inr_r);
  assign srun     = prod_r[63:32];
  assign rec      = prod_r[63:32];
  assign lvl_sum  = $signed({{2{soil_r[31]}}, soil_r}) + $signed({2'b00, rest_r - rec});
  assign cap_s    = $signed({3'b000, cap});
  assign et_div   = min2({12'd0, div_rsp.quotient}, pet_r);

  assign soil_fin = lvl_r - $signed(et_r);
  assign g_sum    = {3'b000, gw_r} + {1'b0, rec_r};
  assign g_sat    = (g_sum > {4'd0, rrwb_pkg::CAP_MAX}) ? rrwb_pkg::CAP_MAX : g_sum[30:0];
  assign gw_fin   = {1'b0, g_sat} - bas_r;
  assign tot      = {2'b00, imp_q_r} + {2'b00, irun_r} + {2'b00, srun_r} + {2'b00, bas_r};
  assign tet      = {2'b00, imp_et_r} + {2'b00, et_r} + {2'b00, intc_r};

  rrwb_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  rrwb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrwb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_series_start ? rrwb_pkg::S_OUT : rrwb_pkg::S_M1;
        end
      end
      rrwb_pkg::S_M1:   state_nxt = rrwb_pkg::S_M2;
      rrwb_pkg::S_M2:   state_nxt = rrwb_pkg::S_M3;
      rrwb_pkg::S_M3:   state_nxt = rrwb_pkg::S_M4;
      rrwb_pkg::S_M4:   state_nxt = rrwb_pkg::S_DIV1;
      rrwb_pkg::S_DIV1: begin
        if (div_rsp.done) begin
          state_nxt = rrwb_pkg::S_M5;
        end
      end
      rrwb_pkg::S_M5:   state_nxt = rrwb_pkg::S_M6;
      rrwb_pkg::S_M6:   state_nxt = rrwb_pkg::S_EXP;
      rrwb_pkg::S_EXP: begin
        if (x_r[bit_r]) begin
          state_nxt = rrwb_pkg::S_EXPW;
        end else if (bit_r == 5'(rrwb_pkg::EXP_BITS - 1)) begin
          state_nxt = rrwb_pkg::S_M7;
        end
      end
      rrwb_pkg::S_EXPW: begin
        state_nxt = (bit_r == 5'(rrwb_pkg::EXP_BITS - 1)) ? rrwb_pkg::S_M7 : rrwb_pkg::S_EXP;
      end
      rrwb_pkg::S_M7:   state_nxt = rrwb_pkg::S_M8;
      rrwb_pkg::S_M8:   state_nxt = rrwb_pkg::S_M9;
      rrwb_pkg::S_M9:   state_nxt = rrwb_pkg::S_M10;
      rrwb_pkg::S_M10:  state_nxt = rrwb_pkg::S_M11;
      rrwb_pkg::S_M11:  state_nxt = rrwb_pkg::S_M12;
      rrwb_pkg::S_M12:  state_nxt = rrwb_pkg::S_M13;
      rrwb_pkg::S_M13:  state_nxt = (lvl_r > 32'sd0) ? rrwb_pkg::S_M14 : rrwb_pkg::S_FIN;
      rrwb_pkg::S_M14:  state_nxt = rrwb_pkg::S_DIV2;
      rrwb_pkg::S_DIV2: begin
        if (div_rsp.done) begin
          state_nxt = rrwb_pkg::S_FIN;
        end
      end
      rrwb_pkg::S_FIN:  state_nxt = rrwb_pkg::S_OUT;
      rrwb_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = rrwb_pkg::S_IDLE;
        end
      end
      default:          state_nxt = rrwb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {5'd0, soil_pos, 16'd0};
    div_req.divisor  = cap;
    case (state_r)
      rrwb_pkg::S_M1: begin
        mul_a = MW'(imp);
        mul_b = MW'(rain_r);
      end
      rrwb_pkg::S_M2: begin
        mul_a = MW'(pf);
        mul_b = MW'(rain_r);
      end
      rrwb_pkg::S_M3: begin
        mul_a = MW'(imp);
        mul_b = MW'(IMPERVIOUS_THRESHOLD);
      end
      rrwb_pkg::S_M4: begin
        div_req.start = 1'b1;
      end
      rrwb_pkg::S_M5: begin
        mul_a = MW'(shape_cfg_r);
        mul_b = MW'(ratio_r);
      end
      rrwb_pkg::S_EXP: begin
        mul_a = acc_r;
        mul_b = MW'(rrwb_pkg::NEG_EXP_TAB[bit_r]);
      end
      rrwb_pkg::S_M7: begin
        mul_a = MW'(icoef_cfg_r);
        mul_b = acc_r;
      end
      rrwb_pkg::S_M8: begin
        mul_a = MW'(sub_f);
        mul_b = MW'(ratio_r);
      end
      rrwb_pkg::S_M9: begin
        mul_a = prod_r[MW-1:0];
        mul_b = MW'(rmo_r);
      end
      rrwb_pkg::S_M10: begin
        mul_a = MW'(crak_f);
        mul_b = MW'(ratio_r);
      end
      rrwb_pkg::S_M11: begin
        mul_a = prod_r[MW-1:0];
        mul_b = MW'(rest_r);
      end
      rrwb_pkg::S_M12: begin
        mul_a = MW'(bf_f);
        mul_b = MW'(gw_r);
      end
      rrwb_pkg::S_M13: begin
        mul_a = MW'(lvl_r[30:0]);
        mul_b = MW'(rrwb_pkg::TEN_MM_Q16);
      end
      rrwb_pkg::S_M14: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r[rrwb_pkg::DIVIDEND_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrwb_pkg::S_IDLE;
      pf_cfg_r    <= rrwb_pkg::PF_RST;
      icap_cfg_r  <= rrwb_pkg::ICAP_RST;
      icoef_cfg_r <= rrwb_pkg::ICOEF_RST;
      shape_cfg_r <= rrwb_pkg::ISHAPE_RST;
      scap_cfg_r  <= rrwb_pkg::SCAP_RST;
      sub_cfg_r   <= rrwb_pkg::SUB_RST;
      crak_cfg_r  <= rrwb_pkg::CRAK_RST;
      bf_cfg_r    <= rrwb_pkg::BF_RST;
      soil_r      <= $signed(rrwb_pkg::SOIL_RST);
      gw_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (rrwb_pkg::reg_index_t'(cfg_index))
          rrwb_pkg::REG_PERVIOUS_FRACTION: pf_cfg_r    <= cfg_data[16:0];
          rrwb_pkg::REG_INTERCEPTION_CAP:  icap_cfg_r  <= cfg_data;
          rrwb_pkg::REG_INFILTRATION_COEF: icoef_cfg_r <= cfg_data;
          rrwb_pkg::REG_INFILTRATION_SHP:  shape_cfg_r <= cfg_data[19:0];
          rrwb_pkg::REG_SOIL_CAPACITY:     scap_cfg_r  <= cfg_data;
          rrwb_pkg::REG_INTERFLOW_COEF:    sub_cfg_r   <= cfg_data[16:0];
          rrwb_pkg::REG_RECHARGE_COEF:     crak_cfg_r  <= cfg_data[16:0];
          rrwb_pkg::REG_BASEFLOW_COEF:     bf_cfg_r    <= cfg_data[16:0];
          default:                         pf_cfg_r    <= pf_cfg_r;
        endcase
      end
      if (state_r == rrwb_pkg::S_IDLE && in_valid && in_series_start) begin
        soil_r <= $signed({2'b00, cap[30:1]});
        gw_r   <= '0;
      end else if (state_r == rrwb_pkg::S_FIN) begin
        soil_r <= soil_fin;
        gw_r   <= gw_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rrwb_pkg::S_IDLE: begin
        rain_r <= in_rainfall;
        pet_r  <= in_potential_et;
        if (in_valid && in_series_start) begin
          out_total_runoff              <= '0;
          out_actual_et                 <= '0;
          out_excess_after_interception <= '0;
          out_interception_loss         <= '0;
          out_direct_runoff             <= '0;
          out_interflow                 <= '0;
          out_infiltration              <= '0;
          out_soil_level                <= $signed({2'b00, cap[30:1]});
          out_recharge                  <= '0;
          out_groundwater_level         <= '0;
          out_soil_et                   <= '0;
          out_baseflow                  <= '0;
        end
      end
      rrwb_pkg::S_M2:   imp_p_r <= prod_r[47:16];
      rrwb_pkg::S_M3:   per_p_r <= prod_r[47:16];
      rrwb_pkg::S_M4: begin
        imp_et_r <= imp_et;
        imp_q_r  <= imp_p_r - imp_et;
        intc_r   <= intc;
        inr_r    <= per_p_r - intc;
      end
      rrwb_pkg::S_DIV1: ratio_r <= div_rsp.quotient[16:0];
      rrwb_pkg::S_M6: begin
        x_r   <= prod_r[35:16];
        acc_r <= 33'h1_0000_0000;
        bit_r <= '0;
      end
      rrwb_pkg::S_EXP: begin
        if (!x_r[bit_r]) begin
          bit_r <= bit_r + 1'b1;
        end
      end
      rrwb_pkg::S_EXPW: begin
        acc_r <= prod_rnd[64:32];
        bit_r <= bit_r + 1'b1;
      end
      rrwb_pkg::S_M8: begin
        rmo_r  <= rmo;
        irun_r <= inr_r - rmo;
      end
      rrwb_pkg::S_M10: begin
        srun_r <= srun;
        rest_r <= rmo_r - srun;
      end
      rrwb_pkg::S_M12: begin
        if (lvl_sum > cap_s) begin
          rec_r <= {2'b00, rec} + 34'(lvl_sum - cap_s);
          lvl_r <= $signed({1'b0, cap});
        end else begin
          rec_r <= {2'b00, rec};
          lvl_r <= lvl_sum[31:0];
        end
      end
      rrwb_pkg::S_M13: begin
        bas_r <= prod_r[47:16];
        et_r  <= '0;
      end
      rrwb_pkg::S_DIV2: et_r <= et_div;
      rrwb_pkg::S_FIN: begin
        out_total_runoff              <= tot[33:32] != 2'b00 ? 32'hFFFF_FFFF : tot[31:0];
        out_actual_et                 <= tet[33:32] != 2'b00 ? 32'hFFFF_FFFF : tet[31:0];
        out_excess_after_interception <= inr_r;
        out_interception_loss         <= intc_r;
        out_direct_runoff             <= irun_r;
        out_interflow                 <= srun_r;
        out_infiltration              <= rmo_r;
        out_soil_level                <= soil_fin;
        out_recharge                  <= rec_r[33:32] != 2'b00 ? 32'hFFFF_FFFF : rec_r[31:0];
        out_groundwater_level         <= $signed(gw_fin);
        out_soil_et                   <= et_r;
        out_baseflow                  <= bas_r;
      end
      default: begin
        rain_r <= rain_r;
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == rrwb_pkg::S_IDLE);
  assign out_valid = (state_r == rrwb_pkg::S_OUT);

endmodule

FILE: hw/rtl/rrwb_checker.sv
// Port-level checker of the water balance block and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rrwb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `RRWB_ASSERT_NOW(a_one_at_a_time, out_valid, !in_ready, "input open while a result waits")
  `RRWB_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after a transaction")
  `RRWB_ASSERT_NEXT(a_idle_after_out, out_valid && out_ready, in_ready && !out_valid, "not idle after a result")
  `RRWB_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid, "result withdrawn")

endmodule

bind rainfall_runoff_water_balance_step rrwb_checker u_rrwb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
